FILE: rtl/core/mmsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsn_pkg: shared types and constants of the min/max sample normaliser
// Sample and result widths, divider sizing and the divider status bundle.
// ----------------------------------------------------------------------------
package mmsn_pkg;

  // Width of a PCM sample, of the running min/max and of the Q1.15 result.
  localparam int SAMPLE_W = 16;
  // Width of the index field of a read transfer.
  localparam int INDEX_W  = 10;
  // Quotient of the scaling divide: at most 65536, so one bit over a sample.
  localparam int QUOT_W   = SAMPLE_W + 1;
  // One quotient bit per divider step.
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SAMPLE_W-1:0] range_t;
  typedef logic        [QUOT_W-1:0]   quot_t;

  // Operation codes of an input transfer.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Status returned by the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/core/mmsn_sample_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsn_sample_ram: block sample store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mmsn_sample_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  mmsn_pkg::sample_t     wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output mmsn_pkg::sample_t     rd_data
);

  mmsn_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mmsn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsn_divider: bit-serial restoring divider for the Q1.15 scaling
// Computes floor((off * 2^17 + d) / (2 * d)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmsn_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mmsn_pkg::range_t      off,
  input  mmsn_pkg::range_t      d,
  output mmsn_pkg::div_status_t status,
  output mmsn_pkg::quot_t       quot
);

  localparam int W = mmsn_pkg::QUOT_W;

  // The partial remainder always stays below the divisor 2*d, so W bits hold it.
  logic [W-1:0]                  rem;
  logic [W-1:0]                  divisor;
  // Low dividend bits still to be brought down; these are simply d.
  logic [W-1:0]                  bits;
  logic [mmsn_pkg::STEP_W-1:0]   step;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       fits;

  assign shifted = {rem, bits[W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rem         <= {1'b0, off};
        divisor     <= {d, 1'b0};
        bits        <= {1'b0, d};
        quot        <= '0;
        step        <= mmsn_pkg::STEP_W'(mmsn_pkg::DIV_STEPS - 1);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        rem  <= fits ? diff[W-1:0] : shifted[W-1:0];
        quot <= {quot[W-2:0], fits};
        bits <= {bits[W-2:0], 1'b0};
        step <= step - 1'b1;
        if (step == '0) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/min_max_sample_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_sample_normalizer_top: block min/max normaliser to Q1.15
// Stores a block of PCM samples with a running minimum and maximum, and
// returns -1 + 2*(x-min)/(max-min) in Q1.15 for a stored sample on request.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-----------------------------------
//  item     | item_valid / item_ready     | operation, first, sample, index
//  result   | result_valid / result_ready | normalized, bad_index, flat_block
//
//  An append transfer completes in the cycle it is accepted and gives no
//  result; item_ready stays high, so appends can follow back to back.
//  A read result is loaded after the store read, the LOAD state that starts
//  the divider, the bit-serial divide (one quotient bit per cycle), the
//  divider's done flag reaching the sequencer and the load of the result
//  register. The next transfer can be accepted in the cycle after that load.
//  A read with a bad index or a flat block skips the divider.
//  item_ready is low from the acceptance of a read until its result is
//  loaded; a loaded result waiting in the output register does not stop the
//  next transfer being accepted, but a second read result waits until the
//  first has been taken.
//  Reset clears the sample count, min/max and the sequencer; the sample
//  store itself is not cleared, as only entries of the current block are read.
// ----------------------------------------------------------------------------
module min_max_sample_normalizer_top #(
  parameter int BLOCK_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 operation,
  input  logic                                 first,
  input  logic signed [mmsn_pkg::SAMPLE_W-1:0] sample,
  input  logic        [mmsn_pkg::INDEX_W-1:0]  index,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [mmsn_pkg::SAMPLE_W-1:0] normalized,
  output logic                                 bad_index,
  output logic                                 flat_block
);

  localparam int ADDR_W = $clog2(BLOCK_DEPTH);
  localparam int CNT_W  = $clog2(BLOCK_DEPTH + 1);
  // Compare width covering both the index field and the sample count.
  localparam int CMP_W  = (CNT_W > mmsn_pkg::INDEX_W) ? CNT_W : mmsn_pkg::INDEX_W;

  typedef enum logic [1:0] {
    IDLE,
    LOAD,
    DIVIDE,
    RESULT
  } state_t;

  state_t state;

  // Block state.
  logic [CNT_W-1:0]  sample_count;
  mmsn_pkg::sample_t running_min;
  mmsn_pkg::sample_t running_max;

  // Per-read working registers.
  mmsn_pkg::range_t  range_d;
  logic              skip_div;
  logic              bad_pend;
  logic              flat_pend;

  // Handshake and decode.
  logic item_fire;
  logic append_fire;
  logic read_fire;
  logic slot_free;

  assign item_ready  = (state == IDLE);
  assign item_fire   = item_valid && item_ready;
  assign append_fire = item_fire && (operation == mmsn_pkg::OP_APPEND);
  assign read_fire   = item_fire && (operation == mmsn_pkg::OP_READ);
  assign slot_free   = !result_valid || result_ready;

  // --------------------------------------------------------------------------
  // Append path: a new block restarts at position zero with min/max at zero,
  // otherwise the sample lands at the current count while there is room.
  // --------------------------------------------------------------------------
  logic              has_room;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  mmsn_pkg::sample_t base_min;
  mmsn_pkg::sample_t base_max;
  logic [CNT_W-1:0]  base_count;

  assign base_min   = first ? '0 : running_min;
  assign base_max   = first ? '0 : running_max;
  assign base_count = first ? '0 : sample_count;
  assign has_room   = (base_count != CNT_W'(BLOCK_DEPTH));
  assign wr_en      = append_fire && has_room;
  assign wr_addr    = base_count[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // Read decode: an index is bad when it is at or past the count (or past the
  // store); the block is flat when max equals min. Either case skips the
  // divide and returns zero.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0]                 idx_wide;
  logic                             bad_now;
  logic                             flat_now;
  logic signed [mmsn_pkg::SAMPLE_W:0] range_wide;

  assign idx_wide   = CMP_W'(index);
  assign bad_now    = (idx_wide >= CMP_W'(sample_count)) ||
                      (idx_wide >= CMP_W'(BLOCK_DEPTH));
  assign flat_now   = (running_max == running_min);
  assign range_wide = {running_max[mmsn_pkg::SAMPLE_W-1], running_max} -
                      {running_min[mmsn_pkg::SAMPLE_W-1], running_min};

  mmsn_pkg::sample_t rd_data;

  mmsn_sample_ram #(
    .DEPTH  (BLOCK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (sample),
    .rd_en   (read_fire),
    .rd_addr (idx_wide[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Offset of the stored sample from the minimum, clamped to the range.
  // --------------------------------------------------------------------------
  logic signed [mmsn_pkg::SAMPLE_W:0] off_wide;
  mmsn_pkg::range_t                   off;

  assign off_wide = {rd_data[mmsn_pkg::SAMPLE_W-1], rd_data} -
                    {running_min[mmsn_pkg::SAMPLE_W-1], running_min};

  always_comb begin
    if (rd_data <= running_min) begin
      off = '0;
    end else if (rd_data >= running_max) begin
      off = range_d;
    end else begin
      off = off_wide[mmsn_pkg::SAMPLE_W-1:0];
    end
  end

  mmsn_pkg::div_status_t div_status;
  mmsn_pkg::quot_t       quot;
  logic                  div_start;

  assign div_start = (state == LOAD) && !skip_div;

  mmsn_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .off    (off),
    .d      (range_d),
    .status (div_status),
    .quot   (quot)
  );

  // Saturate an exact +1.0 and move from offset binary to two's complement.
  mmsn_pkg::range_t q_sat;
  mmsn_pkg::sample_t scaled;

  assign q_sat  = quot[mmsn_pkg::QUOT_W-1] ? '1 : quot[mmsn_pkg::SAMPLE_W-1:0];
  assign scaled = {~q_sat[mmsn_pkg::SAMPLE_W-1], q_sat[mmsn_pkg::SAMPLE_W-2:0]};

  // --------------------------------------------------------------------------
  // Block state updates.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_min  <= '0;
      running_max  <= '0;
    end else if (append_fire) begin
      if (has_room) begin
        sample_count <= base_count + 1'b1;
        running_min  <= (sample < base_min) ? sample : base_min;
        running_max  <= (sample > base_max) ? sample : base_max;
      end else begin
        sample_count <= base_count;
        running_min  <= base_min;
        running_max  <= base_max;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (read_fire) begin
            range_d   <= range_wide[mmsn_pkg::SAMPLE_W-1:0];
            bad_pend  <= bad_now;
            flat_pend <= flat_now;
            skip_div  <= bad_now || flat_now;
            state     <= LOAD;
          end
        end
        LOAD: begin
          state <= skip_div ? RESULT : DIVIDE;
        end
        DIVIDE: begin
          if (div_status.done) begin
            state <= RESULT;
          end
        end
        RESULT: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            normalized   <= skip_div ? '0 : scaled;
            bad_index    <= bad_pend;
            flat_block   <= flat_pend;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/min_max_sample_normalizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_sample_normalizer_top_test: self-checking bench of the normaliser
// Drives append and read transfers into the block and predicts every read
// result from a model of the sample store, the count and the running
// min/max. A short directed table comes first: the extremes of the range, a
// flat block, a bad index and a small range. Random blocks follow, with
// varied sample styles, one block filled past its depth, and changing idle
// patterns on both channels.
// ----------------------------------------------------------------------------
module min_max_sample_normalizer_top_test;

  localparam int DEPTH      = 1024;
  localparam int PHASE_REQS = 40;

  typedef logic [mmsn_pkg::INDEX_W-1:0] index_t;

  // One input transfer.
  typedef struct packed {
    logic                op;
    logic                first;
    mmsn_pkg::sample_t   sample;
    index_t              index;
  } req_t;

  // One read result.
  typedef struct packed {
    mmsn_pkg::sample_t normalized;
    logic              bad_index;
    logic              flat_block;
  } norm_res_t;

  // A row of the directed table. Where typed is set, res holds the result
  // that the row must give; otherwise the result comes from the prediction.
  typedef struct packed {
    req_t      req;
    logic      typed;
    norm_res_t res;
  } dir_row_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  logic               operation    = mmsn_pkg::OP_APPEND;
  logic               first        = 1'b0;
  mmsn_pkg::sample_t  sample       = '0;
  index_t             index        = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  mmsn_pkg::sample_t  normalized;
  logic               bad_index;
  logic               flat_block;

  // Model of the block state.
  mmsn_pkg::sample_t blk_store [DEPTH];
  int                blk_count = 0;
  mmsn_pkg::sample_t blk_min   = '0;
  mmsn_pkg::sample_t blk_max   = '0;
  // Entries below this position have been written at some time since reset,
  // so a bad-index read aimed below it never touches an unwritten entry.
  int        written_hwm = 0;

  norm_res_t norm_expected_q [$];
  int        items_sent     = 0;
  int        mismatches     = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // Directed table. Block A spans the whole 16-bit range, block B is flat,
  // block C is a small positive range with one position past the count,
  // and block D is a small negative range.
  dir_row_t dir_tab [24] = '{
    '{'{mmsn_pkg::OP_APPEND, 1'b1, 16'sd0,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sd32767, 10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sh8000,  10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sd1,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, -16'sd1,    10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sd100,   10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd1}, 1'b1, '{16'sd32767, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd2}, 1'b1, '{16'sh8000, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b1, 16'sd0,     10'd3}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd5}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b1, 16'sd0,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sd0,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd1}, 1'b1, '{16'sd0, 1'b0, 1'b1}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd5}, 1'b1, '{16'sd0, 1'b1, 1'b1}},
    '{'{mmsn_pkg::OP_APPEND, 1'b1, 16'sd5,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, 16'sd3,     10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd0}, 1'b1, '{16'sd32767, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd2}, 1'b1, '{16'sd0, 1'b1, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b1, -16'sd7,    10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_APPEND, 1'b0, -16'sd2,    10'd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd0}, 1'b1, '{16'sh8000, 1'b0, 1'b0}},
    '{'{mmsn_pkg::OP_READ,   1'b0, 16'sd0,     10'd1}, 1'b0, '{16'sd0, 1'b0, 1'b0}}
  };

  min_max_sample_normalizer_top #(
    .BLOCK_DEPTH(DEPTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .operation   (operation),
    .first       (first),
    .sample      (sample),
    .index       (index),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .normalized  (normalized),
    .bad_index   (bad_index),
    .flat_block  (flat_block)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Q1.15 value of a stored sample against the current min and max: the
  // offset from the minimum scaled by 65536 over the span, rounded to the
  // nearest with ties upwards, saturated, then moved down by one half-scale.
  function automatic mmsn_pkg::sample_t scaled_q15(input mmsn_pkg::sample_t x);
    longint span;
    longint offs;
    longint q;
    span = longint'(blk_max) - longint'(blk_min);
    offs = longint'(x) - longint'(blk_min);
    if (offs < 0) offs = 0;
    if (offs > span) offs = span;
    q = (offs * 131072 + span) / (2 * span);
    if (q > 65535) q = 65535;
    return mmsn_pkg::sample_t'(q - 32768);
  endfunction

  // Applies one accepted transfer to the model of the block. Returns 1 with
  // the predicted result for a read; an append changes the state only.
  function automatic bit predict_transfer(input req_t r, output norm_res_t res);
    res = '0;
    if (r.op == mmsn_pkg::OP_APPEND) begin
      if (r.first) begin
        blk_count = 0;
        blk_min   = '0;
        blk_max   = '0;
      end
      // A full block ignores a further append unless it starts a new block.
      if (blk_count < DEPTH) begin
        blk_store[blk_count] = r.sample;
        blk_count++;
        if (r.sample < blk_min) blk_min = r.sample;
        if (r.sample > blk_max) blk_max = r.sample;
        if (blk_count > written_hwm) written_hwm = blk_count;
      end
      return 1'b0;
    end
    res.flat_block = (blk_max == blk_min);
    res.bad_index  = (int'(r.index) >= blk_count);
    if (!res.bad_index && !res.flat_block) begin
      res.normalized = scaled_q15(blk_store[r.index]);
    end
    return 1'b1;
  endfunction

  // Presents one transfer, with a random idle gap in front of it, and waits
  // for it to be accepted. Valid is only lowered inside an idle gap, so it
  // stays high from one transfer into the next when there is no gap.
  task automatic send_item(input req_t r, input logic typed, input norm_res_t typed_res);
    norm_res_t res;
    norm_res_t queued;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= r.op;
    first      <= r.first;
    sample     <= r.sample;
    index      <= r.index;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (!(r.op == mmsn_pkg::OP_APPEND && !r.first && blk_count == DEPTH)) items_sent++;
    if (predict_transfer(r, res)) begin
      queued          = typed ? typed_res : res;
      norm_expected_q = {norm_expected_q, queued};
    end
  endtask

  // The sender holds off until every read result has been transferred.
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (norm_expected_q.size() != 0) @(posedge clk);
  endtask

  // A sample in one of several styles: anywhere in the range, close around
  // zero, all zero (which gives a flat block), or mostly the extremes.
  function automatic mmsn_pkg::sample_t block_sample(input int style);
    case (style)
      0: return mmsn_pkg::sample_t'($urandom);
      1: return mmsn_pkg::sample_t'(int'($urandom_range(30)) - 15);
      2: return '0;
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sd32767;
          2: return '0;
          default: return mmsn_pkg::sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Mostly a stored position of the current block; sometimes one at or past the
  // count, but only where that entry has been written in an earlier block.
  function automatic index_t read_position();
    if (written_hwm > blk_count && $urandom_range(99) < 15) begin
      return index_t'($urandom_range(written_hwm - 1, blk_count));
    end
    if (blk_count == 0) return '0;
    return index_t'($urandom_range(blk_count - 1, 0));
  endfunction

  // A read with random, unused sample and first fields.
  function automatic req_t read_req();
    req_t r;
    r.op     = mmsn_pkg::OP_READ;
    r.first  = 1'($urandom_range(1));
    r.sample = mmsn_pkg::sample_t'($urandom);
    r.index  = read_position();
    return r;
  endfunction

  // One block of appends with reads mixed in. Most blocks are short; a few
  // are long, and now and then a stray first restarts the block mid-way.
  task automatic random_block();
    int   len;
    int   style;
    int   n_app;
    req_t r;
    len   = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(16, 1);
    style = $urandom_range(3);
    n_app = 0;
    while (n_app < len) begin
      if (n_app > 0 && $urandom_range(99) < 45) begin
        r = read_req();
      end else begin
        r.op     = mmsn_pkg::OP_APPEND;
        r.first  = (n_app == 0) || ($urandom_range(99) == 0);
        r.sample = block_sample(style);
        r.index  = index_t'($urandom);
        n_app++;
      end
      send_item(r, 1'b0, '0);
    end
  endtask

  // Fills one block to its depth, then offers appends that must be ignored,
  // and reads back positions including the last one.
  task automatic full_block_pass();
    int   n;
    int   style;
    req_t r;
    style = $urandom_range(3);
    for (n = 0; n < DEPTH + 4; n++) begin
      r.op     = mmsn_pkg::OP_APPEND;
      r.first  = (n == 0);
      r.sample = (n >= DEPTH) ? block_sample(3) : block_sample(style);
      r.index  = index_t'($urandom);
      send_item(r, 1'b0, '0);
      if ($urandom_range(99) < 4) send_item(read_req(), 1'b0, '0);
    end
    r       = read_req();
    r.index = index_t'(DEPTH - 1);
    send_item(r, 1'b0, '0);
    for (n = 0; n < 20; n++) send_item(read_req(), 1'b0, '0);
  endtask

  // Compares one result field with the oldest expectation.
  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Result side: checks each transfer, then decides whether to stall the
  // next cycle. result_ready gets exactly one assignment per clock edge.
  initial begin
    norm_res_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (norm_expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual normalized=%0d bad=%0b flat=%0b",
                   $time, normalized, bad_index, flat_block);
        end else begin
          want = norm_expected_q.pop_front();
          check_field("normalized", want.normalized, normalized);
          check_field("bad_index", want.bad_index, bad_index);
          check_field("flat_block", want.flat_block, flat_block);
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus. The directed table runs without idling; then eight random
  // phases cycle through the idle patterns. Each phase opens with the sender
  // held off until every result is in, and the first one also fills a block.
  initial begin
    int   ph;
    int   goal;
    req_t r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      r = dir_tab[i].req;
      send_item(r, dir_tab[i].typed, dir_tab[i].res);
    end
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      hold_until_drained();
      if (ph == 0) full_block_pass();
      goal = items_sent + PHASE_REQS;
      while (items_sent < goal) random_block();
    end
    hold_until_drained();
    // Let any stray late result show itself before the verdict.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
